FILE: hw/rtl/wakeup_latency_table_core_defines.svh
// Assertion macros used by the checker file.
`ifndef WAKEUP_LATENCY_TABLE_CORE_DEFINES_SVH
`define WAKEUP_LATENCY_TABLE_CORE_DEFINES_SVH

// Plain implication property, clocked and disabled in reset.
`define WLT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal holds its value in the cycle after cond.
`define WLT_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
    else $error(msg);

`endif

FILE: hw/rtl/wlt_pkg.sv
// Package: widths, codes and the table entry type of the wake-up latency table.
`timescale 1ns / 1ps
package wlt_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned KEY_W         = 32;
  localparam int unsigned TIME_W        = 64;
  localparam int unsigned NAME_W        = 64;

  localparam logic FUNC_WAKE   = 1'b0;
  localparam logic FUNC_SWITCH = 1'b1;

  typedef struct packed {
    logic              used;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stamp;
  } entry_t;

endpackage

FILE: hw/rtl/wlt_in_if.sv
// Request channel carrying scheduler events into the table.
`timescale 1ns / 1ps
interface wlt_in_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [wlt_pkg::KEY_W-1:0] woken_task;
  logic [wlt_pkg::KEY_W-1:0] outgoing_task;
  logic [wlt_pkg::KEY_W-1:0] incoming_task;
  logic [wlt_pkg::TIME_W-1:0] now_time;
  logic [wlt_pkg::NAME_W-1:0] name_low;
  logic [wlt_pkg::NAME_W-1:0] name_high;

  modport source (output valid, func, woken_task, outgoing_task, incoming_task,
                  now_time, name_low, name_high, input ready);
  modport sink   (input valid, func, woken_task, outgoing_task, incoming_task,
                  now_time, name_low, name_high, output ready);
endinterface

FILE: hw/rtl/wlt_out_if.sv
// Result channel carrying measured wait times out of the table.
`timescale 1ns / 1ps
interface wlt_out_if;
  logic                       valid;
  logic                       ready;
  logic [wlt_pkg::KEY_W-1:0]  task_id;
  logic [wlt_pkg::TIME_W-1:0] wait_time;
  logic [wlt_pkg::NAME_W-1:0] task_name_low;
  logic [wlt_pkg::NAME_W-1:0] task_name_high;

  modport source (output valid, task_id, wait_time, task_name_low, task_name_high,
                  input ready);
  modport sink   (input valid, task_id, wait_time, task_name_low, task_name_high,
                   output ready);
endinterface

FILE: hw/rtl/wlt_mem.sv
// Table storage: one write port, one read port with registered data.
`timescale 1ns / 1ps
module wlt_mem #(
  parameter int unsigned Depth = wlt_pkg::TABLE_ENTRIES,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  wlt_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output wlt_pkg::entry_t rdata_o
);

  wlt_pkg::entry_t mem_q [Depth];
  wlt_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/wakeup_latency_table_core.sv
// Top level: keyed table of task wake-up stamps that reports wake-to-run latency.
// Usage: a wakeup request stores now_time under woken_task (overwrite if present,
// dropped if new and the table is full). A switch request with a non-zero
// incoming_task removes outgoing_task, then looks up incoming_task and, on a hit
// with a key other than outgoing_task, removes it and returns id, now_time minus
// stored stamp (mod 2^64) and the name. Timing: a switch with incoming_task zero
// completes in the accept cycle. Every other request holds ready low while it
// makes one pass over the table through its single read port (one entry a cycle,
// both keys compared at once), waits for the last registered read data, then
// passes the write states WR_A and WR_B. A request that produces a result then
// loads the result register in ST_EMIT, and stays there while an earlier result
// is still held unaccepted. A result waiting in the output register does not
// stop the next request from being accepted. After reset the table is swept
// once to clear the used bits, and no request is accepted during the sweep.
`timescale 1ns / 1ps
module wakeup_latency_table_core #(
  parameter int unsigned TableEntries = wlt_pkg::TABLE_ENTRIES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wlt_in_if.sink    in_if,
  wlt_out_if.source out_if
);

  localparam int unsigned AW = $clog2(TableEntries);
  localparam int unsigned CW = $clog2(TableEntries + 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_WR_A  = 3'd3;
  localparam logic [2:0] ST_WR_B  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic                        func_q;
  logic [wlt_pkg::KEY_W-1:0]   key_a_q, key_b_q;
  logic [wlt_pkg::TIME_W-1:0]  now_q;
  logic [wlt_pkg::NAME_W-1:0]  name_lo_q, name_hi_q;

  logic          rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  logic          a_hit_q, b_hit_q, f_hit_q;
  logic [AW-1:0] a_idx_q, b_idx_q, f_idx_q;
  logic [wlt_pkg::TIME_W-1:0] b_stamp_q;

  logic                       out_vld_q;
  logic [wlt_pkg::KEY_W-1:0]  out_id_q;
  logic [wlt_pkg::TIME_W-1:0] out_wait_q;
  logic [wlt_pkg::NAME_W-1:0] out_nl_q, out_nh_q;

  logic            in_acc, start, rd_en, out_load;
  logic            match_a, match_b, is_free;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  wlt_pkg::entry_t mem_wdata, rd_entry;

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign start       = in_acc && !(in_if.func == wlt_pkg::FUNC_SWITCH &&
                                   in_if.incoming_task == '0);
  assign rd_en       = (state_q == ST_SCAN) && (cnt_q != CW'(TableEntries));
  assign out_load    = (state_q == ST_EMIT) && (!out_vld_q || out_if.ready);

  assign match_a = rd_vld_q && rd_entry.used && (rd_entry.key == key_a_q);
  assign match_b = rd_vld_q && rd_entry.used && (rd_entry.key == key_b_q);
  assign is_free = rd_vld_q && !rd_entry.used;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(TableEntries - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cnt_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          cnt_d = cnt_q + CW'(1);
        end else if (!rd_vld_q) begin
          state_d = ST_WR_A;
        end
      end
      ST_WR_A: state_d = ST_WR_B;
      ST_WR_B: begin
        if (func_q == wlt_pkg::FUNC_SWITCH && b_hit_q && key_a_q != key_b_q) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // write port: clearing sweep, outgoing removal, then wakeup store or incoming removal
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = a_idx_q;
    mem_wdata = '{used: 1'b0, key: key_a_q, stamp: now_q};
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[AW-1:0];
        mem_wdata = '0;
      end
      ST_WR_A: begin
        mem_we = (func_q == wlt_pkg::FUNC_SWITCH) && a_hit_q;
      end
      ST_WR_B: begin
        if (func_q == wlt_pkg::FUNC_WAKE) begin
          mem_we         = a_hit_q || f_hit_q;
          mem_waddr      = a_hit_q ? a_idx_q : f_idx_q;
          mem_wdata.used = 1'b1;
        end else begin
          mem_we    = b_hit_q && (key_a_q != key_b_q);
          mem_waddr = b_idx_q;
        end
      end
      default: ;
    endcase
  end

  wlt_mem #(
    .Depth(TableEntries)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (rd_en),
    .raddr_i(cnt_q[AW-1:0]),
    .rdata_o(rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      a_hit_q   <= 1'b0;
      b_hit_q   <= 1'b0;
      f_hit_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_en;
      if (start) begin
        a_hit_q <= 1'b0;
        b_hit_q <= 1'b0;
        f_hit_q <= 1'b0;
      end else begin
        if (match_a) a_hit_q <= 1'b1;
        if (match_b) b_hit_q <= 1'b1;
        if (is_free) f_hit_q <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // keys are unique in the table, so the first match is the only one
  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q[AW-1:0];
    if (in_acc) begin
      func_q    <= in_if.func;
      key_a_q   <= (in_if.func == wlt_pkg::FUNC_SWITCH) ? in_if.outgoing_task
                                                        : in_if.woken_task;
      key_b_q   <= in_if.incoming_task;
      now_q     <= in_if.now_time;
      name_lo_q <= in_if.name_low;
      name_hi_q <= in_if.name_high;
    end
    if (match_a && !a_hit_q) a_idx_q <= rd_idx_q;
    if (match_b && !b_hit_q) begin
      b_idx_q   <= rd_idx_q;
      b_stamp_q <= rd_entry.stamp;
    end
    if (is_free && !f_hit_q) f_idx_q <= rd_idx_q;
    if (out_load) begin
      out_id_q   <= key_b_q;
      out_wait_q <= now_q - b_stamp_q;
      out_nl_q   <= name_lo_q;
      out_nh_q   <= name_hi_q;
    end
  end

  assign out_if.valid          = out_vld_q;
  assign out_if.task_id        = out_id_q;
  assign out_if.wait_time      = out_wait_q;
  assign out_if.task_name_low  = out_nl_q;
  assign out_if.task_name_high = out_nh_q;

endmodule

FILE: hw/rtl/wlt_checker.sv
// Port-level checker for the wake-up latency table, bound to the top level.
`timescale 1ns / 1ps
`include "wakeup_latency_table_core_defines.svh"
module wlt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       in_func_i,
  input logic [wlt_pkg::KEY_W-1:0]  in_incoming_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [wlt_pkg::KEY_W-1:0]  task_id_i,
  input logic [wlt_pkg::TIME_W-1:0] wait_time_i
);

  logic in_start;
  logic out_stall;

  // an idle switch completes in the accept cycle and leaves ready high
  assign in_start  = in_valid_i && in_ready_i &&
                     !(in_func_i == wlt_pkg::FUNC_SWITCH && in_incoming_i == '0);
  assign out_stall = out_valid_i && !out_ready_i;

  `WLT_ASSERT(a_busy_after_req, clk_i, rst_ni, in_start |=> !in_ready_i, "busy after request")
  `WLT_ASSERT(a_id_nonzero, clk_i, rst_ni, out_valid_i |-> task_id_i != '0, "zero task id")
  `WLT_ASSERT(a_out_held, clk_i, rst_ni, out_stall |=> out_valid_i, "result dropped")
  `WLT_ASSERT_HOLD(a_wait_held, clk_i, rst_ni, out_stall, wait_time_i, "wait time changed")

endmodule

bind wakeup_latency_table_core wlt_checker u_wlt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .in_func_i    (in_if.func),
  .in_incoming_i(in_if.incoming_task),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .task_id_i    (out_if.task_id),
  .wait_time_i  (out_if.wait_time)
);
